FILE: rtl/core/kcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_pkg: shared types and constants of the keypad calculator core
// Key kinds, pending-operation codes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int unsigned DATA_W = 16;

	// entry stops taking digits at or above this value (signed compare)
	localparam logic signed [DATA_W-1:0] ENTRY_LIMIT = 16'sd3276;

	typedef enum logic [1:0] {
		KIND_DIGIT  = 2'd0,
		KIND_OPER   = 2'd1,
		KIND_MODE   = 2'd2,
		KIND_EQUALS = 2'd3
	} kind_t;

	// pending operation; an operator key k below KEY_CLEAR selects code k+1
	typedef enum logic [3:0] {
		OPC_NONE = 4'd0,
		OPC_ADD  = 4'd1,
		OPC_SUB  = 4'd2,
		OPC_DIV  = 4'd3,
		OPC_MUL  = 4'd4,
		OPC_AND  = 4'd5,
		OPC_OR   = 4'd6,
		OPC_NOT  = 4'd7,
		OPC_XOR  = 4'd8
	} opc_t;

	localparam logic [3:0] KEY_CLEAR = 4'd8;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture the incoming key
		logic div_start;  // launch the divider
		logic commit;     // update calculator state
		logic out_load;   // load the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_div;   // key runs a divide with a nonzero divisor
		logic div_done;   // quotient ready this cycle
	} sts_t;

endpackage

FILE: rtl/core/kcc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncates
// toward zero. Result wraps to the data width.
// ----------------------------------------------------------------------------
module kcc_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [kcc_pkg::DATA_W-1:0]        dividend,
	input  logic [kcc_pkg::DATA_W-1:0]        divisor,
	output logic                              done,
	output logic [kcc_pkg::DATA_W-1:0]        quotient
);

	localparam int unsigned W     = kcc_pkg::DATA_W;
	localparam int unsigned CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     den_q;
	logic             neg_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [W:0]   rem_sh;
	logic         ge;
	logic [W-1:0] mag_a;
	logic [W-1:0] mag_b;

	assign mag_a  = dividend[W-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b  = divisor[W-1]  ? (~divisor + 1'b1)  : divisor;
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder stays below the divisor, so W bits hold it
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			den_q <= mag_b;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			rem_q <= ge ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

FILE: rtl/core/kcc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_datapath: calculator state, ALU and result register
// Holds entry, operands, last result and mode; applies one key per commit.
// ----------------------------------------------------------------------------
module kcc_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  kcc_pkg::cmd_t                cmd,
	output kcc_pkg::sts_t                sts,
	input  logic [15:0]                  s_tdata,
	input  logic [1:0]                   s_tuser,
	output logic [15:0]                  m_tdata,
	output logic [1:0]                   m_tuser
);

	localparam int unsigned W = kcc_pkg::DATA_W;

	// captured key
	kcc_pkg::kind_t kind_q;
	logic [3:0]     dig_q;
	logic [3:0]     key_q;
	logic           sel_q;

	// calculator state
	logic [W-1:0]   entry_q, left_q, right_q, last_q;
	kcc_pkg::opc_t  pend_q;
	logic           bin_q, sne_q, dso_q, dz_q;

	logic [W-1:0]   entry_n, left_n, right_n, last_n;
	kcc_pkg::opc_t  pend_n;
	logic           bin_n, sne_n, dso_n, dz_n;

	logic [W-1:0]   out_data_q;
	logic [1:0]     out_user_q;

	logic           run;
	logic           hit;
	logic [W-1:0]   res;
	logic [2*W-1:0] prod;
	logic [W-1:0]   shifted;
	logic           div_done;
	logic [W-1:0]   quotient;

	kcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (left_q),
		.divisor  (right_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign run  = (kind_q == kcc_pkg::KIND_EQUALS) ||
	              ((kind_q == kcc_pkg::KIND_OPER) && dso_q);
	assign prod = left_q * right_q;

	assign sts.need_div = run && (pend_q == kcc_pkg::OPC_DIV) && (right_q != '0);
	assign sts.div_done = div_done;

	// times 2 or times 10 plus digit, wraps
	assign shifted = bin_q ? ({entry_q[W-2:0], 1'b0} + W'(dig_q))
	                       : ({entry_q[W-4:0], 3'b000} + {entry_q[W-2:0], 1'b0} + W'(dig_q));

	always_comb begin
		hit = 1'b1;
		res = last_q;
		dz_n = 1'b0;
		unique case (pend_q)
			kcc_pkg::OPC_ADD: res = left_q + right_q;
			kcc_pkg::OPC_SUB: res = left_q - right_q;
			kcc_pkg::OPC_MUL: res = prod[W-1:0];
			kcc_pkg::OPC_AND: res = left_q & right_q;
			kcc_pkg::OPC_OR:  res = left_q | right_q;
			kcc_pkg::OPC_XOR: res = left_q ^ right_q;
			kcc_pkg::OPC_NOT: res = ~entry_q;
			kcc_pkg::OPC_DIV: begin
				if (right_q == '0) begin
					dz_n = run;
				end else begin
					res = quotient;
				end
			end
			default: hit = 1'b0;
		endcase

		entry_n = entry_q;
		left_n  = left_q;
		right_n = right_q;
		last_n  = last_q;
		pend_n  = pend_q;
		bin_n   = bin_q;
		sne_n   = sne_q;
		dso_n   = dso_q;

		unique case (kind_q)
			kcc_pkg::KIND_DIGIT: begin
				dz_n = 1'b0;
				if (sne_q) begin
					entry_n = W'(dig_q);
					sne_n   = 1'b0;
				end else if ($signed(entry_q) < kcc_pkg::ENTRY_LIMIT) begin
					entry_n = shifted;
				end
				right_n = entry_n;
				dso_n   = 1'b1;
			end
			kcc_pkg::KIND_MODE: begin
				dz_n  = 1'b0;
				bin_n = sel_q;
			end
			default: begin
				if (run) begin
					sne_n = 1'b1;
					if (hit) begin
						last_n  = res;
						left_n  = res;
						entry_n = res;
					end else begin
						left_n = entry_q;
					end
				end
				if (kind_q == kcc_pkg::KIND_OPER) begin
					if (key_q < kcc_pkg::KEY_CLEAR) begin
						pend_n = kcc_pkg::opc_t'(key_q + 4'd1);
					end else if (key_q == kcc_pkg::KEY_CLEAR) begin
						pend_n  = kcc_pkg::OPC_NONE;
						entry_n = '0;
						left_n  = '0;
						right_n = '0;
						last_n  = '0;
					end
				end
				dso_n = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
			left_q  <= '0;
			right_q <= '0;
			last_q  <= '0;
			pend_q  <= kcc_pkg::OPC_NONE;
			bin_q   <= 1'b0;
			sne_q   <= 1'b0;
			dso_q   <= 1'b1;
			dz_q    <= 1'b0;
		end else if (cmd.commit) begin
			entry_q <= entry_n;
			left_q  <= left_n;
			right_q <= right_n;
			last_q  <= last_n;
			pend_q  <= pend_n;
			bin_q   <= bin_n;
			sne_q   <= sne_n;
			dso_q   <= dso_n;
			dz_q    <= dz_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kcc_pkg::kind_t'(s_tuser);
			dig_q  <= s_tdata[3:0];
			key_q  <= s_tdata[7:4];
			sel_q  <= s_tdata[8];
		end
		if (cmd.out_load) begin
			out_data_q <= entry_q;
			out_user_q <= {dz_q, bin_q};
		end
	end

	assign m_tdata = out_data_q;
	assign m_tuser = out_user_q;

endmodule

FILE: rtl/core/kcc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kcc_ctrl: key sequencer
// Accepts a key, waits on the divider when needed, hands off the result.
// ----------------------------------------------------------------------------
module kcc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output kcc_pkg::cmd_t cmd,
	input  kcc_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.load = s_tvalid;
			ST_DECIDE: begin
				cmd.div_start = sts.need_div;
				cmd.commit    = !sts.need_div;
			end
			ST_DIV_WAIT: cmd.commit = sts.div_done;
			ST_OUT:      cmd.out_load = out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= sts.need_div ? ST_DIV_WAIT : ST_OUT;
				end
				ST_DIV_WAIT: begin
					if (sts.div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

`ifndef SYNTHESIS
	// one key in flight at a time
	a_single_key: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("kcc_ctrl: second key taken while one is in progress");

	// divider result never arrives in the launch cycle's successor
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !cmd.commit)
		else $error("kcc_ctrl: commit right after divider launch");

	// result register only reloaded when its transfer is done or empty
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("kcc_ctrl: pending result overwritten");

	// every commit is followed by a result hand-off before the next key
	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> !s_tready)
		else $error("kcc_ctrl: ready before result was handed off");
`endif

endmodule

FILE: rtl/core/keypad_calculator_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_calculator_controller_core: 16-bit signed keypad calculator
// One key event in, one display update out, per transfer.
// ----------------------------------------------------------------------------
// Each accepted key produces exactly one result transfer carrying the value now
// shown, the entry mode and a divide-by-zero flag. Keys are processed one at a
// time: a digit, mode select or any non-divide operation goes through accept,
// execute and hand-off, after which the next key is taken. A divide that
// actually runs goes through the iterative divider, which resolves one quotient
// bit per cycle: accept, launch, one step per quotient bit, a step in which the
// quotient is ready and committed, then hand-off.
// The result sits in an output register, so the next
// key may be accepted while the previous result still waits for m_tready; the
// core only stalls before loading a new result into an occupied register.
// Reset clears all calculator state: entry, operands, last result, pending
// operation and mode (decimal).
// ----------------------------------------------------------------------------
module keypad_calculator_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	// key input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [3:0] digit, [7:4] op_key, [8] select_binary, rest 0
	input  logic [1:0]  s_tuser,  // [1:0] operation (key kind)
	// display output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] display_value, two's complement
	output logic [1:0]  m_tuser   // [0] binary_mode, [1] divide_by_zero
);

	kcc_pkg::cmd_t cmd;
	kcc_pkg::sts_t sts;

	// sequencer: handshakes and step ordering
	kcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// datapath: state registers, ALU, divider, result register
	kcc_datapath u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for keypad_calculator_controller_core
// Drives key events on the input stream and compares every display transfer
// against an in-bench calculator model, across directed, random and stall runs.
// ----------------------------------------------------------------------------
module tb;

	// operator key codes as they travel in op_key
	localparam logic [3:0] KEY_ADD   = 4'd0;
	localparam logic [3:0] KEY_SUB   = 4'd1;
	localparam logic [3:0] KEY_DIV   = 4'd2;
	localparam logic [3:0] KEY_MUL   = 4'd3;
	localparam logic [3:0] KEY_AND   = 4'd4;
	localparam logic [3:0] KEY_OR    = 4'd5;
	localparam logic [3:0] KEY_NOT   = 4'd6;
	localparam logic [3:0] KEY_XOR   = 4'd7;
	localparam logic [3:0] KEY_OTHER = 4'd9;
	localparam logic [3:0] KEY_TOP   = 4'd15;

	typedef struct packed {
		logic [15:0] value;
		logic        bin;
		logic        dz;
	} disp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;

	disp_t shown_q[$];
	int    mismatch_cnt = 0;
	bit    tx_idle = 1'b1;
	bit    rx_idle = 1'b1;
	int    hold_req = 0;

	// calculator state as the bench sees it
	logic [15:0]    c_entry, c_left, c_right, c_result;
	kcc_pkg::opc_t  c_pend;
	logic           c_bin, c_fresh, c_digit_seen;

	keypad_calculator_controller_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	// completes the pending operation; returns 1 on a divide by zero
	function automatic logic calc_pending();
		logic [15:0] r;
		logic        dz;
		int          q;
		r  = c_result;
		dz = 1'b0;
		case (c_pend)
			kcc_pkg::OPC_ADD: r = c_left + c_right;
			kcc_pkg::OPC_SUB: r = c_left - c_right;
			kcc_pkg::OPC_MUL: r = c_left * c_right;
			kcc_pkg::OPC_AND: r = c_left & c_right;
			kcc_pkg::OPC_OR:  r = c_left | c_right;
			kcc_pkg::OPC_XOR: r = c_left ^ c_right;
			kcc_pkg::OPC_NOT: r = ~c_entry;
			kcc_pkg::OPC_DIV: begin
				if (c_right != 16'd0) begin
					q = int'($signed(c_left)) / int'($signed(c_right));
					r = q[15:0];
				end else begin
					dz = 1'b1; // keep the old result
				end
			end
			default: begin
				c_left  = c_entry;
				c_fresh = 1'b1;
				return 1'b0;
			end
		endcase
		c_result = r;
		c_left   = r;
		c_entry  = r;
		c_fresh  = 1'b1;
		return dz;
	endfunction

	function automatic disp_t calc_key(kcc_pkg::kind_t kind, logic [3:0] dig,
			logic [3:0] key, logic sel);
		logic dz;
		dz = 1'b0;
		case (kind)
			kcc_pkg::KIND_DIGIT: begin
				if (c_fresh) begin
					c_entry = {12'd0, dig};
					c_fresh = 1'b0;
				end else if ($signed(c_entry) < kcc_pkg::ENTRY_LIMIT) begin
					c_entry = c_entry * (c_bin ? 16'd2 : 16'd10) + {12'd0, dig};
				end
				c_right      = c_entry;
				c_digit_seen = 1'b1;
			end
			kcc_pkg::KIND_OPER: begin
				if (c_digit_seen)
					dz = calc_pending();
				if (key < kcc_pkg::KEY_CLEAR) begin
					c_pend = kcc_pkg::opc_t'(key + 4'd1);
				end else if (key == kcc_pkg::KEY_CLEAR) begin
					c_pend   = kcc_pkg::OPC_NONE;
					c_entry  = '0;
					c_left   = '0;
					c_right  = '0;
					c_result = '0;
				end
				c_digit_seen = 1'b0;
			end
			kcc_pkg::KIND_MODE: c_bin = sel;
			default: begin
				dz = calc_pending();
				c_digit_seen = 1'b0;
			end
		endcase
		return '{value: c_entry, bin: c_bin, dz: dz};
	endfunction

	// one key transfer; starts and ends on a falling edge
	task automatic press(input kcc_pkg::kind_t kind, input logic [3:0] dig,
			input logic [3:0] key, input logic sel);
		int gap;
		gap = tx_idle ? $urandom_range(0, 13) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, sel, key, dig};
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		shown_q.push_back(calc_key(kind, dig, key, sel));
		@(negedge clk);
	endtask

	task automatic digit(input logic [3:0] d);
		press(kcc_pkg::KIND_DIGIT, d, 4'($urandom), 1'($urandom));
	endtask

	task automatic oper(input logic [3:0] k);
		press(kcc_pkg::KIND_OPER, 4'($urandom), k, 1'($urandom));
	endtask

	task automatic equals();
		press(kcc_pkg::KIND_EQUALS, 4'($urandom), 4'($urandom), 1'($urandom));
	endtask

	task automatic test_directed();
		// entry saturation, then add wraps to the most negative value
		digit(4'd3); digit(4'd2); digit(4'd7); digit(4'd5); digit(4'd9); digit(4'd9);
		oper(KEY_ADD); digit(4'd9); equals();
		// operator straight after equals runs nothing
		oper(KEY_SUB); digit(4'd15); equals();
		oper(KEY_MUL); digit(4'd7); equals();
		// divide by zero, then a real divide
		oper(KEY_DIV); digit(4'd0); oper(KEY_DIV); digit(4'd3); equals();
		oper(KEY_AND); digit(4'd12); oper(KEY_OR); digit(4'd5); oper(KEY_XOR);
		digit(4'd6); oper(KEY_NOT); equals();
		// out-of-table key keeps the pending op
		oper(KEY_OTHER); equals();
		// binary entry with an out-of-range digit
		press(kcc_pkg::KIND_MODE, 4'($urandom), 4'($urandom), 1'b1);
		digit(4'd1); digit(4'd1); digit(4'd15);
		press(kcc_pkg::KIND_MODE, 4'($urandom), 4'($urandom), 1'b0);
		oper(kcc_pkg::KEY_CLEAR); digit(4'd4); oper(KEY_TOP); equals();
	endtask

	// mostly calculator-like key sequences with some noise
	task automatic test_random(input int count);
		kcc_pkg::kind_t kind;
		logic [3:0]     dig, key;
		logic           sel;
		int             r;
		for (int i = 0; i < count; i++) begin
			r   = $urandom_range(0, 99);
			dig = 4'($urandom);
			key = 4'($urandom);
			sel = 1'($urandom);
			if (r < 45) begin
				kind = kcc_pkg::KIND_DIGIT;
				if ($urandom_range(0, 15) == 0)
					dig = 4'($urandom_range(0, 15));
				else if ($urandom_range(0, 7) == 0)
					dig = 4'd0; // feeds divide by zero
				else
					dig = c_bin ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 9));
			end else if (r < 75) begin
				kind = kcc_pkg::KIND_OPER;
				key = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
				                                  : 4'($urandom_range(0, 7));
			end else if (r < 82) begin
				kind = kcc_pkg::KIND_MODE;
			end else begin
				kind = kcc_pkg::KIND_EQUALS;
			end
			press(kind, dig, key, sel);
		end
	endtask

	// long receiver hold-off while keys keep coming back to back
	task automatic test_backpressure();
		tx_idle  = 1'b0;
		hold_req = 300;
		test_random(40);
		tx_idle  = 1'b1;
	endtask

	// result sink: random stall per transfer, long hold-off on request
	initial begin
		int stall;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_idle ? $urandom_range(0, 13) : 0;
			if (hold_req != 0) begin
				stall    = hold_req;
				hold_req = 0;
			end
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// compare each display transfer with the oldest prediction
	always @(posedge clk) begin
		disp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (shown_q.size() == 0) begin
				$display("%0t unexpected transfer: expected none, actual value %h user %b",
					$time, m_tdata, m_tuser);
				mismatch_cnt++;
			end else begin
				want = shown_q.pop_front();
				if (m_tdata !== want.value) begin
					$display("%0t display_value: expected %h, actual %h",
						$time, want.value, m_tdata);
					mismatch_cnt++;
				end
				if (m_tuser[0] !== want.bin) begin
					$display("%0t binary_mode: expected %b, actual %b",
						$time, want.bin, m_tuser[0]);
					mismatch_cnt++;
				end
				if (m_tuser[1] !== want.dz) begin
					$display("%0t divide_by_zero: expected %b, actual %b",
						$time, want.dz, m_tuser[1]);
					mismatch_cnt++;
				end
			end
		end
	end

	initial begin
		c_entry      = '0;
		c_left       = '0;
		c_right      = '0;
		c_result     = '0;
		c_pend       = kcc_pkg::OPC_NONE;
		c_bin        = 1'b0;
		c_fresh      = 1'b0;
		c_digit_seen = 1'b1;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_directed();
		test_random(600);
		test_backpressure();
		// no idling on either side
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		test_random(150);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		test_random(460);

		s_tvalid <= 1'b0;
		while (shown_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatch_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
